// ===== rtl/core/shash_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shash_pkg
// shared types, round constants and sigma functions for the sha-256 hasher
// ----------------------------------------------------------------------------
package shash_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SC_HOLD,
        SC_BYTE,
        SC_LEN,
        SC_STEP,
        SC_CLEAR
    } t_sched_op;

    typedef enum logic [2:0] {
        VR_HOLD,
        VR_LOAD,
        VR_ROUND,
        VR_ADD,
        VR_INIT
    } t_vars_op;

    typedef struct packed {
        t_sched_op   sched_op;
        logic [7:0]  byte_val;
        logic [5:0]  byte_pos;
        logic [63:0] msg_len;
        t_vars_op    vars_op;
        logic [5:0]  round_idx;
        logic [2:0]  out_idx;
    } t_ctrl;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return f_rotr(x, 5'd2) ^ f_rotr(x, 5'd13) ^ f_rotr(x, 5'd22);
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return f_rotr(x, 5'd6) ^ f_rotr(x, 5'd11) ^ f_rotr(x, 5'd25);
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return f_rotr(x, 5'd7) ^ f_rotr(x, 5'd18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return f_rotr(x, 5'd17) ^ f_rotr(x, 5'd19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/shash_sched.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shash_sched
// 16-word message schedule window: byte packing, length insert, expansion
// ----------------------------------------------------------------------------
module shash_sched (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire shash_pkg::t_ctrl  i_ctrl,
    output logic [31:0]            o_w
);

    logic [31:0] r_w [16];
    logic [31:0] n_next_w;
    logic [4:0]  byte_lsb;

    // w[t+16] from the window holding w[t..t+15]
    assign n_next_w = shash_pkg::f_ssig1(r_w[14]) + r_w[9]
                    + shash_pkg::f_ssig0(r_w[1]) + r_w[0];

    // big-endian lane inside the word
    assign byte_lsb = {~i_ctrl.byte_pos[1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_w[i] <= '0;
        end else begin
            unique case (i_ctrl.sched_op)
                shash_pkg::SC_HOLD: begin
                end
                shash_pkg::SC_BYTE: begin
                    r_w[i_ctrl.byte_pos[5:2]][byte_lsb +: 8] <= i_ctrl.byte_val;
                end
                shash_pkg::SC_LEN: begin
                    r_w[14] <= i_ctrl.msg_len[63:32];
                    r_w[15] <= i_ctrl.msg_len[31:0];
                end
                shash_pkg::SC_STEP: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= n_next_w;
                end
                shash_pkg::SC_CLEAR: begin
                    for (int i = 0; i < 16; i++) r_w[i] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_w = r_w[0];

endmodule
`default_nettype wire

// ===== rtl/core/shash_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shash_round
// shared compression round unit with working variables and hash words
// ----------------------------------------------------------------------------
module shash_round (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire shash_pkg::t_ctrl  i_ctrl,
    input  wire logic [31:0]       i_w,
    output logic [31:0]            o_hash_word
);

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + shash_pkg::f_bsig1(r_v[4]) + ch
            + shash_pkg::K_TABLE[i_ctrl.round_idx] + i_w;
        t2  = shash_pkg::f_bsig0(r_v[0]) + maj;
    end

    // working variables a..h
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.vars_op)
            shash_pkg::VR_LOAD: begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            shash_pkg::VR_ROUND: begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            shash_pkg::VR_HOLD, shash_pkg::VR_ADD, shash_pkg::VR_INIT: begin
            end
            default: begin
            end
        endcase
    end

    // chaining hash words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= shash_pkg::H_INIT[i];
        end else begin
            unique case (i_ctrl.vars_op)
                shash_pkg::VR_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                end
                shash_pkg::VR_INIT: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= shash_pkg::H_INIT[i];
                end
                shash_pkg::VR_HOLD, shash_pkg::VR_LOAD, shash_pkg::VR_ROUND: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_hash_word = r_h[i_ctrl.out_idx];

endmodule
`default_nettype wire

// ===== rtl/core/shash_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shash_ctrl
// sequencer: byte count, bit length, round count, padding and digest output
// ----------------------------------------------------------------------------
module shash_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic         i_kind,
    input  wire logic [7:0]   i_data_byte,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [2:0]        o_word_index,
    output logic              o_last_word,
    output shash_pkg::t_ctrl  o_ctrl
);

    shash_pkg::t_state r_state;
    shash_pkg::t_state n_state;
    logic [5:0]  r_pos;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic        r_two;
    logic [2:0]  r_idx;
    logic        in_acc;
    logic        out_acc;
    logic        pad_late;
    logic        emit_done;

    assign o_in_stall  = (r_state != shash_pkg::ST_IDLE);
    assign o_out_valid = (r_state == shash_pkg::ST_EMIT);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign emit_done   = out_acc && (r_idx == 3'd7);
    // pad byte in the last eight bytes: length needs a block of its own
    assign pad_late    = (r_pos >= 6'd56);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shash_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (!i_kind) begin
                        n_state = (r_pos == 6'd63) ? shash_pkg::ST_ROUND
                                                   : shash_pkg::ST_IDLE;
                    end else begin
                        n_state = pad_late ? shash_pkg::ST_ROUND
                                           : shash_pkg::ST_LEN;
                    end
                end
            end
            shash_pkg::ST_LEN: begin
                n_state = shash_pkg::ST_ROUND;
            end
            shash_pkg::ST_ROUND: begin
                if (r_rnd == 6'd63) n_state = shash_pkg::ST_FINAL;
            end
            shash_pkg::ST_FINAL: begin
                priority if (r_fin && r_two) n_state = shash_pkg::ST_LEN;
                else if (r_fin)              n_state = shash_pkg::ST_EMIT;
                else                         n_state = shash_pkg::ST_IDLE;
            end
            shash_pkg::ST_EMIT: begin
                if (emit_done) n_state = shash_pkg::ST_IDLE;
            end
            default: begin
                n_state = shash_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.sched_op  = shash_pkg::SC_HOLD;
        o_ctrl.vars_op   = shash_pkg::VR_HOLD;
        o_ctrl.byte_val  = i_kind ? shash_pkg::PAD_BYTE : i_data_byte;
        o_ctrl.byte_pos  = r_pos;
        o_ctrl.msg_len   = r_len;
        o_ctrl.round_idx = r_rnd;
        o_ctrl.out_idx   = r_idx;
        unique case (r_state)
            shash_pkg::ST_IDLE: begin
                if (in_acc) begin
                    o_ctrl.sched_op = shash_pkg::SC_BYTE;
                    if (n_state == shash_pkg::ST_ROUND) o_ctrl.vars_op = shash_pkg::VR_LOAD;
                end
            end
            shash_pkg::ST_LEN: begin
                o_ctrl.sched_op = shash_pkg::SC_LEN;
                o_ctrl.vars_op  = shash_pkg::VR_LOAD;
            end
            shash_pkg::ST_ROUND: begin
                o_ctrl.sched_op = shash_pkg::SC_STEP;
                o_ctrl.vars_op  = shash_pkg::VR_ROUND;
            end
            shash_pkg::ST_FINAL: begin
                o_ctrl.sched_op = shash_pkg::SC_CLEAR;
                o_ctrl.vars_op  = shash_pkg::VR_ADD;
            end
            shash_pkg::ST_EMIT: begin
                if (emit_done) o_ctrl.vars_op = shash_pkg::VR_INIT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shash_pkg::ST_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_pos <= r_pos + 6'd1;
                if (!i_kind) begin
                    r_len <= r_len + 64'd8;
                end else begin
                    r_fin <= 1'b1;
                    r_two <= pad_late;
                end
            end
            if (r_state == shash_pkg::ST_LEN) r_two <= 1'b0;
            if (r_state == shash_pkg::ST_ROUND) r_rnd <= r_rnd + 6'd1;
            if (out_acc) r_idx <= r_idx + 3'd1;
            if (emit_done) begin
                r_pos <= '0;
                r_len <= '0;
                r_fin <= 1'b0;
            end
        end
    end

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == 3'd7);

`ifndef SYNTHESIS
    a_rnd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != shash_pkg::ST_ROUND) |-> (r_rnd == 6'd0))
        else $error("round counter not zero outside compression");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != shash_pkg::ST_EMIT) |-> (r_idx == 3'd0))
        else $error("digest index not zero outside output");
    a_fin_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shash_pkg::ST_FINAL && r_fin && !r_two)
        |=> (r_state == shash_pkg::ST_EMIT))
        else $error("final block did not lead to digest output");
    a_emit_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shash_pkg::ST_EMIT) |-> (r_fin && !r_two))
        else $error("digest output without a finished message");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// byte-serial sha-256 hasher with one shared round unit
// ----------------------------------------------------------------------------
//  channel  valid        stall         payload
//  in       i_in_valid   o_in_stall    i_kind, i_data_byte
//  out      o_out_valid  i_out_stall   o_digest_word, o_word_index, o_last_word
//
//  a data beat is taken only in idle; the beat that fills a 64-byte block
//  starts the rounds through the one round unit, then hash add and
//  schedule clear, and no new byte is taken until these are done
//  end of message: pad, length insert, rounds, add; a pad byte in the last
//  eight bytes takes rounds and add first; then eight out beats
//  reset is synchronous and loads the initial hash words, no clearing pass
//  o_in_stall is high from a filled block to its hash add, and from end of
//  message to the last digest beat; i_out_stall holds the current digest word
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    // control bundle from the sequencer to both datapath parts
    shash_pkg::t_ctrl ctrl;
    // current schedule word w[t] for the round unit
    logic [31:0]      sched_w;

    // sequencer: counts bytes, bit length and rounds, drives the out beats
    shash_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_ctrl       (ctrl)
    );

    // message schedule: packs bytes big-endian, expands one word per round
    shash_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_w     (sched_w)
    );

    // round unit: one compression round per cycle, holds the hash words
    shash_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_w         (sched_w),
        .o_hash_word (o_digest_word)
    );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the byte-serial sha-256 hasher against an in-bench copy of the
// hash: every accepted byte and end mark updates the bench's own message
// state, each end mark queues the eight digest words it must produce, and
// every digest beat is checked field by field against the oldest one queued
// ----------------------------------------------------------------------------
module tb;

    // input beat kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // padding byte that follows the message
    localparam logic [7:0] PAD_MARK = 8'h80;

    // run timing, in clock cycles, and run size targets
    localparam int RESET_CYCLES  = 6;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int ITEM_TARGET   = 420;
    localparam int MSG_TARGET    = 16;

    // initial hash words
    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // per-round additive constants
    localparam logic [31:0] ROUND_KEYS [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_msg_beat;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    // receiver stall patterns, re-picked at random from the receiver's tick counter
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_CYCLIC
    } t_stall_mode;

    // dut ports, inputs all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_kind      = KIND_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // beats waiting to be driven, and digest words still owed by the dut
    t_msg_beat    pending_beats [$];
    t_digest_beat digest_due [$];

    // bench copy of the message state
    logic [31:0] hash_acc [8];
    logic [31:0] blk_words [16];
    logic [63:0] msg_bits;
    logic [5:0]  fill_pos;

    // handshake bookkeeping
    logic        in_taken    = 1'b0;
    int          beats_fed   = 0;
    int          err_count   = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    t_msg_beat   head_beat;

    // receiver side
    logic        hold_off    = 1'b0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_tick  = 0;

    sha256_stream_hasher_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // hash prediction
    // ------------------------------------------------------------------------

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_message();
        for (int i = 0; i < 8; i++) hash_acc[i] = IV_WORDS[i];
        for (int i = 0; i < 16; i++) blk_words[i] = 32'h0;
        msg_bits = 64'h0;
        fill_pos = 6'd0;
    endtask

    // one full compression of the current block into the hash words,
    // the block buffer starts over empty afterwards
    task automatic run_compression();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 16; r++) w[r] = blk_words[r];
        for (int r = 16; r < 64; r++) begin
            w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10))
                 + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
                 + w[r-16];
        end
        {a, b, c, d, e, f, g, h} = {hash_acc[0], hash_acc[1], hash_acc[2], hash_acc[3],
                                    hash_acc[4], hash_acc[5], hash_acc[6], hash_acc[7]};
        for (int r = 0; r < 64; r++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                   + ((e & f) ^ (~e & g)) + ROUND_KEYS[r] + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                   + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        hash_acc[0] += a;
        hash_acc[1] += b;
        hash_acc[2] += c;
        hash_acc[3] += d;
        hash_acc[4] += e;
        hash_acc[5] += f;
        hash_acc[6] += g;
        hash_acc[7] += h;
        for (int i = 0; i < 16; i++) blk_words[i] = 32'h0;
    endtask

    // bytes pack big-endian into the schedule words
    task automatic place_byte(input logic [7:0] b);
        blk_words[fill_pos[5:2]] |= {24'h0, b} << (24 - 8 * fill_pos[1:0]);
        fill_pos = fill_pos + 6'd1;
    endtask

    // advance the bench state by one accepted beat
    task automatic absorb_beat(input logic kind, input logic [7:0] data);
        logic [5:0]   start_pos;
        t_digest_beat beat;
        if (kind == KIND_DATA) begin
            place_byte(data);
            msg_bits += 64'd8;
            if (fill_pos == 6'd0) run_compression();
        end else begin
            start_pos = fill_pos;
            place_byte(PAD_MARK);
            // pad in the last eight bytes: the length needs a fresh block
            if (start_pos >= 6'd56) run_compression();
            blk_words[14] = msg_bits[63:32];
            blk_words[15] = msg_bits[31:0];
            run_compression();
            for (int i = 0; i < 8; i++) begin
                beat.word = hash_acc[i];
                beat.idx  = 3'(i);
                beat.last = (i == 7);
                digest_due.push_back(beat);
            end
            clear_message();
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("mismatch: %s got %h want %h", what, got, want);
    endtask

    task automatic check_digest_beat();
        t_digest_beat want;
        if (digest_due.size() == 0) begin
            report_mismatch("digest beat with none pending", o_digest_word, 32'h0);
        end else begin
            want = digest_due.pop_front();
            if (o_digest_word !== want.word)
                report_mismatch("digest_word", o_digest_word, want.word);
            if (o_word_index !== want.idx)
                report_mismatch("word_index", {29'h0, o_word_index}, {29'h0, want.idx});
            if (o_last_word !== want.last)
                report_mismatch("last_word", {31'h0, o_last_word}, {31'h0, want.last});
        end
    endtask

    // monitor: everything is sampled on the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                absorb_beat(i_kind, i_data_byte);
                beats_fed++;
            end
            if (o_out_valid && !i_out_stall)
                check_digest_beat();
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sender: bursts of random length separated by random gaps, a beat only
    // moves on once taken so a stalled payload holds still
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                head_beat    = pending_beats.pop_front();
                i_in_valid  <= 1'b1;
                i_kind      <= head_beat.kind;
                i_data_byte <= head_beat.data;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    // about a third of the bursts run straight into the next
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern of its own, plus the long hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : out_stall_gen
        logic pick;
        case (stall_mode)
            STALL_NONE: begin
                pick = 1'b0;
            end
            STALL_COIN: begin
                pick = ($urandom_range(0, 1) == 0);
            end
            default: begin
                pick = (stall_tick % 5) < 3;
            end
        endcase
        i_out_stall <= hold_off || pick;
        stall_tick  <= stall_tick + 1;
        if (stall_tick % 64 == 63)
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
    end

    // once digest words are on offer mid-run, refuse them for a long stretch
    // while the sender keeps pushing, so the input side backs up
    initial begin : hold_seq
        while (!(beats_fed > 150 && o_out_valid)) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // watchdog: too long with no beat moving either way
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic push_beat(input logic kind, input logic [7:0] data);
        t_msg_beat beat;
        beat.kind = kind;
        beat.data = data;
        pending_beats.push_back(beat);
    endtask

    // random content, then the end mark with an ignored random byte
    task automatic add_message(input int len);
        for (int i = 0; i < len; i++) push_beat(KIND_DATA, 8'($urandom_range(0, 255)));
        push_beat(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin : main_seq
        int total;
        int msgs;
        int fixed_lens [5];

        clear_message();

        // directed: empty message, "abc", single extreme bytes, back to back
        // end marks and a byte left in the end mark's data field
        push_beat(KIND_END, 8'h00);
        push_beat(KIND_DATA, 8'h61);
        push_beat(KIND_DATA, 8'h62);
        push_beat(KIND_DATA, 8'h63);
        push_beat(KIND_END, 8'hff);
        push_beat(KIND_DATA, 8'h00);
        push_beat(KIND_END, 8'h00);
        push_beat(KIND_DATA, 8'hff);
        push_beat(KIND_END, 8'h5a);
        push_beat(KIND_END, 8'ha5);
        push_beat(KIND_DATA, 8'h55);
        push_beat(KIND_DATA, 8'h80);
        push_beat(KIND_DATA, 8'haa);
        push_beat(KIND_END, 8'h80);
        msgs = 6;

        // block edges: pad just fits, pad at byte 56, pad in the last byte,
        // pad opening a new block, and a message spanning two blocks
        fixed_lens = '{55, 56, 63, 64, 119};
        foreach (fixed_lens[i]) begin
            add_message(fixed_lens[i]);
            msgs++;
        end

        // random lengths, mostly short, some around one block
        while (pending_beats.size() < ITEM_TARGET || msgs < MSG_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                add_message($urandom_range(50, 70));
            else
                add_message($urandom_range(0, 12));
            msgs++;
        end
        total = pending_beats.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_fed < total) @(posedge i_clk);
        while (digest_due.size() != 0) @(posedge i_clk);
        // let any stray beat show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
